// ===== src/tnp_pkg.sv =====
// Shared types, codes and a helper function for the timer node pool.
package tnp_pkg;

	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_RELOAD = 2'd2,
		ACT_CANCEL = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_EMPTY    = 2'd1,
		STS_BAD_NODE = 2'd2,
		STS_NO_MATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] owner;
		logic [31:0] tag;
		logic [31:0] interval;
		logic [47:0] deadline;
	} node_t;

	localparam logic [47:0] DEADLINE_MAX = 48'hFFFF_FFFF_FFFF;

	function automatic logic [47:0] sat_add48(input logic [47:0] base, input logic [31:0] add);
		logic [48:0] sum;
		sum = {1'b0, base} + {17'd0, add};
		return sum[48] ? DEADLINE_MAX : sum[47:0];
	endfunction

endpackage

// ===== src/timer_node_pool_core.sv =====
// Timer node pool: free-list allocator of timer nodes held in two synchronous RAMs.
// Allocate, free and reload pass through S_EXEC; no new item is taken before the result is out.
// Requests refused up front (empty pool, zero owner, index out of range) return the next cycle.
// Cancel-by-owner scans the node RAM one entry per cycle, from entry 0 to the last entry.
// After reset a clearing pass initializes both RAMs while busy is high.
// Each result is shown for one cycle with done; the receiver cannot stall it.
module timer_node_pool_core #(
	parameter int NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [5:0]  node_index,
	input  logic [15:0] owner_handle,
	input  logic [31:0] user_tag,
	input  logic [31:0] delay_ms,
	input  logic [31:0] interval_ms,
	input  logic [47:0] reference_ms,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  node_out,
	output logic [47:0] deadline_ms,
	output logic        periodic,
	output logic [6:0]  freed_count,
	output logic [6:0]  used_count
);

	import tnp_pkg::*;

	localparam int IW = $clog2(NODES);
	localparam int LW = $clog2(NODES + 1);
	localparam int NW = $bits(node_t);
	localparam logic [LW-1:0] NODES_L = LW'(NODES);
	localparam logic [IW-1:0] LAST_I = IW'(NODES - 1);

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_SCAN
	} state_t;

	state_t        state_q;
	logic [IW-1:0] scan_q;
	logic [LW-1:0] head_q;
	logic [LW-1:0] used_q;
	logic [LW-1:0] freed_q;

	action_t       act_q;
	logic [5:0]    idx_q;
	logic [15:0]   owner_q;
	logic [31:0]   tag_q;
	logic [31:0]   delay_q;
	logic [31:0]   interval_q;
	logic [47:0]   ref_q;

	logic          done_q;
	status_t       res_status_q;
	logic [5:0]    res_node_q;
	logic [47:0]   res_deadline_q;
	logic          res_periodic_q;
	logic [6:0]    res_freed_q;
	logic [6:0]    res_used_q;

	logic          node_we;
	logic [IW-1:0] node_waddr;
	node_t         node_wdata;
	logic [IW-1:0] node_raddr;
	logic [NW-1:0] node_rdata;
	node_t         node_rd;
	logic          link_we;
	logic [IW-1:0] link_waddr;
	logic [LW-1:0] link_wdata;
	logic [IW-1:0] link_raddr;
	logic [LW-1:0] link_rd;

	logic          in_idx_ok;
	logic [IW-1:0] head_idx;
	logic [IW-1:0] cmd_idx;
	logic [31:0]   add_val;
	logic [47:0]   sum_deadline;
	logic          match;
	logic [LW-1:0] freed_next;
	logic [LW-1:0] used_next;

	tnp_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	tnp_ram #(.WIDTH(LW), .DEPTH(NODES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rd)
	);

	assign node_rd      = node_t'(node_rdata);
	assign in_idx_ok    = 32'(node_index) < 32'(NODES);
	assign head_idx     = head_q[IW-1:0];
	assign cmd_idx      = IW'(idx_q);
	assign add_val      = (act_q == ACT_ALLOC) ? delay_q : node_rd.interval;
	assign sum_deadline = sat_add48(ref_q, add_val);
	assign match        = node_rd.owner == owner_q;
	assign freed_next   = freed_q + LW'(match);
	assign used_next    = used_q - LW'(match);

	always_comb begin
		node_we    = 1'b0;
		node_waddr = cmd_idx;
		node_wdata = node_rd;
		link_we    = 1'b0;
		link_waddr = cmd_idx;
		link_wdata = head_q;
		link_raddr = head_idx;
		if (state_q == S_SCAN) begin
			node_raddr = IW'(scan_q + IW'(1));
		end else if (action_t'(action) == ACT_CANCEL) begin
			node_raddr = '0;
		end else begin
			node_raddr = IW'(node_index);
		end
		case (state_q)
			S_INIT: begin
				node_we    = 1'b1;
				node_waddr = scan_q;
				node_wdata = '0;
				link_we    = 1'b1;
				link_waddr = scan_q;
				link_wdata = LW'(scan_q) + LW'(1);
			end
			S_EXEC: begin
				case (act_q)
					ACT_ALLOC: begin
						node_we             = 1'b1;
						node_waddr          = head_idx;
						node_wdata.owner    = owner_q;
						node_wdata.tag      = tag_q;
						node_wdata.interval = interval_q;
						node_wdata.deadline = sum_deadline;
					end
					ACT_FREE: begin
						if (node_rd.owner != '0) begin
							node_we          = 1'b1;
							node_wdata.owner = '0;
							link_we          = 1'b1;
						end
					end
					ACT_RELOAD: begin
						if (node_rd.owner != '0 && node_rd.interval != '0) begin
							node_we             = 1'b1;
							node_wdata.deadline = sum_deadline;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if (match) begin
					node_we          = 1'b1;
					node_waddr       = scan_q;
					node_wdata.owner = '0;
					link_we          = 1'b1;
					link_waddr       = scan_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_INIT;
			scan_q         <= '0;
			head_q         <= '0;
			used_q         <= '0;
			freed_q        <= '0;
			act_q          <= ACT_ALLOC;
			idx_q          <= '0;
			owner_q        <= '0;
			tag_q          <= '0;
			delay_q        <= '0;
			interval_q     <= '0;
			ref_q          <= '0;
			done_q         <= 1'b0;
			res_status_q   <= STS_OK;
			res_node_q     <= '0;
			res_deadline_q <= '0;
			res_periodic_q <= 1'b0;
			res_freed_q    <= '0;
			res_used_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					scan_q <= IW'(scan_q + IW'(1));
					if (scan_q == LAST_I) begin
						scan_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						act_q          <= action_t'(action);
						idx_q          <= node_index;
						owner_q        <= owner_handle;
						tag_q          <= user_tag;
						delay_q        <= delay_ms;
						interval_q     <= interval_ms;
						ref_q          <= reference_ms;
						res_status_q   <= STS_OK;
						res_node_q     <= '0;
						res_deadline_q <= '0;
						res_periodic_q <= 1'b0;
						res_freed_q    <= '0;
						res_used_q     <= 7'(used_q);
						case (action_t'(action))
							ACT_ALLOC: begin
								if (head_q == NODES_L) begin
									done_q       <= 1'b1;
									res_status_q <= STS_EMPTY;
								end else if (owner_handle == '0) begin
									done_q       <= 1'b1;
									res_status_q <= STS_BAD_NODE;
								end else begin
									state_q <= S_EXEC;
								end
							end
							ACT_FREE, ACT_RELOAD: begin
								res_node_q <= node_index;
								if (!in_idx_ok) begin
									done_q       <= 1'b1;
									res_status_q <= STS_BAD_NODE;
								end else begin
									state_q <= S_EXEC;
								end
							end
							ACT_CANCEL: begin
								if (owner_handle == '0) begin
									done_q       <= 1'b1;
									res_status_q <= STS_NO_MATCH;
								end else begin
									scan_q  <= '0;
									freed_q <= '0;
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_EXEC: begin
					state_q        <= S_IDLE;
					done_q         <= 1'b1;
					res_status_q   <= STS_OK;
					res_node_q     <= idx_q;
					res_deadline_q <= '0;
					res_periodic_q <= 1'b0;
					res_freed_q    <= '0;
					res_used_q     <= 7'(used_q);
					case (act_q)
						ACT_ALLOC: begin
							head_q         <= link_rd;
							used_q         <= used_q + LW'(1);
							res_used_q     <= 7'(used_q + LW'(1));
							res_node_q     <= 6'(head_q);
							res_deadline_q <= sum_deadline;
						end
						ACT_FREE: begin
							if (node_rd.owner == '0) begin
								res_status_q <= STS_BAD_NODE;
							end else begin
								head_q     <= LW'(idx_q);
								used_q     <= used_q - LW'(1);
								res_used_q <= 7'(used_q - LW'(1));
							end
						end
						ACT_RELOAD: begin
							if (node_rd.owner == '0) begin
								res_status_q <= STS_BAD_NODE;
							end else if (node_rd.interval == '0) begin
								res_deadline_q <= node_rd.deadline;
							end else begin
								res_deadline_q <= sum_deadline;
								res_periodic_q <= 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					freed_q <= freed_next;
					used_q  <= used_next;
					scan_q  <= IW'(scan_q + IW'(1));
					if (match) begin
						head_q <= LW'(scan_q);
					end
					if (scan_q == LAST_I) begin
						state_q        <= S_IDLE;
						done_q         <= 1'b1;
						res_status_q   <= (freed_next == '0) ? STS_NO_MATCH : STS_OK;
						res_node_q     <= '0;
						res_deadline_q <= '0;
						res_periodic_q <= 1'b0;
						res_freed_q    <= 7'(freed_next);
						res_used_q     <= 7'(used_next);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = res_status_q;
	assign node_out    = res_node_q;
	assign deadline_ms = res_deadline_q;
	assign periodic    = res_periodic_q;
	assign freed_count = res_freed_q;
	assign used_count  = res_used_q;

	// The tables change only while an operation or the clearing pass is running.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !node_we && !link_we)
		else $error("RAM write while idle");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= NODES_L)
		else $error("in-use count exceeds pool size");

	// The free list is empty exactly when every node is in use.
	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_INIT |-> ((head_q == NODES_L) == (used_q == NODES_L)))
		else $error("free list head disagrees with in-use count");

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> state_q == S_IDLE && done_q)
		else $error("second cycle did not complete the transfer");

endmodule

// ===== src/tnp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module tnp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== bench/tnp_check_pkg.sv =====
// Request and reply types and the scoreboard that predicts the timer node pool.
package tnp_check_pkg;

	import tnp_pkg::*;

	localparam int POOL_NODES = 64;

	typedef struct {
		action_t     action;
		logic [5:0]  node;
		logic [15:0] owner;
		logic [31:0] tag;
		logic [31:0] delay;
		logic [31:0] interval;
		logic [47:0] reference;
	} request_t;

	typedef struct {
		status_t     status;
		logic [5:0]  node;
		logic [47:0] deadline;
		logic        periodic;
		logic [6:0]  freed;
		logic [6:0]  used;
	} reply_t;

	class node_pool_scoreboard;

		logic [15:0] owner_of [POOL_NODES];
		logic [31:0] tag_of [POOL_NODES];
		logic [31:0] interval_of [POOL_NODES];
		logic [47:0] deadline_of [POOL_NODES];
		int          link_of [POOL_NODES];
		int          free_head;
		int          in_use;
		reply_t      expected_replies [$];
		int          mismatches;

		function new();
			for (int n = 0; n < POOL_NODES; n++) begin
				owner_of[n] = '0;
				link_of[n] = n + 1;
			end
			free_head = 0;
			in_use = 0;
			mismatches = 0;
		endfunction

		function logic [47:0] expiry(logic [47:0] base, logic [31:0] add);
			logic [48:0] sum;
			sum = {1'b0, base} + {17'd0, add};
			return sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
		endfunction

		function void release_node(int n);
			link_of[n] = free_head;
			free_head = n;
			owner_of[n] = '0;
			if (in_use > 0)
				in_use--;
		endfunction

		function bit in_use_at(int n);
			return owner_of[n] != 16'd0;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		function string reply_text(reply_t r);
			return $sformatf("status=%s node=%0d deadline=%h periodic=%0d freed=%0d used=%0d",
				r.status.name(), r.node, r.deadline, r.periodic, r.freed, r.used);
		endfunction

		function void note_request(request_t r);
			reply_t e;
			int     n;
			e = '{STS_OK, 6'd0, 48'd0, 1'b0, 7'd0, 7'd0};
			n = int'(r.node);
			case (r.action)
				ACT_ALLOC: begin
					if (free_head >= POOL_NODES) begin
						e.status = STS_EMPTY;
					end else if (r.owner == 16'd0) begin
						e.status = STS_BAD_NODE;
					end else begin
						n = free_head;
						free_head = link_of[n];
						owner_of[n] = r.owner;
						tag_of[n] = r.tag;
						interval_of[n] = r.interval;
						deadline_of[n] = expiry(r.reference, r.delay);
						in_use++;
						e.node = 6'(n);
						e.deadline = deadline_of[n];
					end
				end
				ACT_FREE: begin
					e.node = r.node;
					if (owner_of[n] == 16'd0)
						e.status = STS_BAD_NODE;
					else
						release_node(n);
				end
				ACT_RELOAD: begin
					e.node = r.node;
					if (owner_of[n] == 16'd0) begin
						e.status = STS_BAD_NODE;
					end else if (interval_of[n] == 32'd0) begin
						e.deadline = deadline_of[n];
					end else begin
						deadline_of[n] = expiry(r.reference, interval_of[n]);
						e.deadline = deadline_of[n];
						e.periodic = 1'b1;
					end
				end
				default: begin
					if (r.owner != 16'd0) begin
						for (int i = 0; i < POOL_NODES; i++) begin
							if (owner_of[i] == r.owner) begin
								release_node(i);
								e.freed++;
							end
						end
					end
					if (e.freed == 7'd0)
						e.status = STS_NO_MATCH;
				end
			endcase
			e.used = 7'(in_use);
			expected_replies.push_back(e);
		endfunction

		function void check_result(reply_t got);
			reply_t want;
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %s", reply_text(got));
				return;
			end
			want = expected_replies.pop_front();
			if (got.status !== want.status || got.node !== want.node ||
					got.deadline !== want.deadline || got.periodic !== want.periodic ||
					got.freed !== want.freed || got.used !== want.used) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected %s", reply_text(want));
					$display("          actual   %s", reply_text(got));
				end
			end
		endfunction

		function void close_out();
			reply_t want;
			while (expected_replies.size() != 0) begin
				want = expected_replies.pop_front();
				mismatches++;
				if (mismatches <= 10)
					$display("missing result: %s", reply_text(want));
			end
		endfunction

	endclass

endpackage

// ===== bench/timer_node_pool_core_test.sv =====
// Top-level testbench that drives the timer node pool and checks every result.
module timer_node_pool_core_test;

	import tnp_pkg::*;
	import tnp_check_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	action_t     action;
	logic [5:0]  node_index;
	logic [15:0] owner_handle;
	logic [31:0] user_tag;
	logic [31:0] delay_ms;
	logic [31:0] interval_ms;
	logic [47:0] reference_ms;
	logic        done;
	logic [1:0]  status;
	logic [5:0]  node_out;
	logic [47:0] deadline_ms;
	logic        periodic;
	logic [6:0]  freed_count;
	logic [6:0]  used_count;

	node_pool_scoreboard sb = new();

	int idle_plan [4] = '{0, 63, 37, 0};
	int alloc_plan [4] = '{60, 95, 25, 80};

	timer_node_pool_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.node_index   (node_index),
		.owner_handle (owner_handle),
		.user_tag     (user_tag),
		.delay_ms     (delay_ms),
		.interval_ms  (interval_ms),
		.reference_ms (reference_ms),
		.done         (done),
		.status       (status),
		.node_out     (node_out),
		.deadline_ms  (deadline_ms),
		.periodic     (periodic),
		.freed_count  (freed_count),
		.used_count   (used_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{status_t'(status), node_out, deadline_ms, periodic,
				freed_count, used_count});
	end

	function automatic request_t make_request(action_t act, logic [5:0] node,
			logic [15:0] owner, logic [31:0] tag, logic [31:0] delay,
			logic [31:0] interval, logic [47:0] reference);
		return '{act, node, owner, tag, delay, interval, reference};
	endfunction

	task automatic send_request(input request_t r);
		@(negedge clk);
		action <= r.action;
		node_index <= r.node;
		owner_handle <= r.owner;
		user_tag <= r.tag;
		delay_ms <= r.delay;
		interval_ms <= r.interval;
		reference_ms <= r.reference;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(r);
	endtask

	task automatic idle_cycle();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_request(input int alloc_pct, output request_t r);
		int live [$];
		int roll;
		for (int n = 0; n < POOL_NODES; n++)
			if (sb.in_use_at(n))
				live.push_back(n);
		r.tag = $urandom;
		r.delay = $urandom;
		r.interval = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom);
		r.reference[47:32] = 16'($urandom);
		r.reference[31:0] = $urandom;
		if ($urandom_range(7) == 0)
			r.reference = 48'hFFFF_FFFF_FFFF - 48'($urandom);
		roll = $urandom_range(99);
		if (roll < 85)
			r.owner = 16'($urandom_range(1, 4));
		else if (roll < 95)
			r.owner = 16'($urandom);
		else if (roll < 98)
			r.owner = 16'hFFFF;
		else
			r.owner = 16'd0;
		if (live.size() > 0 && $urandom_range(99) < 85)
			r.node = 6'(live[$urandom_range(live.size() - 1)]);
		else
			r.node = 6'($urandom_range(63));
		if ($urandom_range(99) < alloc_pct) begin
			r.action = ACT_ALLOC;
		end else begin
			roll = $urandom_range(99);
			if (roll < 45) begin
				r.action = ACT_FREE;
			end else if (roll < 90) begin
				r.action = ACT_RELOAD;
			end else begin
				r.action = ACT_CANCEL;
				if (live.size() > 0 && $urandom_range(99) < 80)
					r.owner = sb.owner_of[live[$urandom_range(live.size() - 1)]];
			end
		end
	endtask

	initial begin
		request_t r;
		int       pct;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_ALLOC;
		node_index = '0;
		owner_handle = '0;
		user_tag = '0;
		delay_ms = '0;
		interval_ms = '0;
		reference_ms = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		send_request(make_request(ACT_RELOAD, 6'd0, 16'd0, '0, '0, '0, '0));
		send_request(make_request(ACT_FREE, 6'd63, 16'd1, '0, '0, '0, '0));
		send_request(make_request(ACT_CANCEL, 6'd0, 16'd0, '0, '0, '0, '0));
		send_request(make_request(ACT_CANCEL, 6'd0, 16'd5, '0, '0, '0, '0));
		send_request(make_request(ACT_ALLOC, 6'h2A, 16'd0, '1, '1, '1, '1));
		send_request(make_request(ACT_ALLOC, 6'd0, 16'hFFFF, '1, '1, '1, '1));
		send_request(make_request(ACT_ALLOC, 6'd0, 16'd1, '0, '0, '0, '0));
		send_request(make_request(ACT_ALLOC, 6'h3F, 16'h8000, 32'hA5A5_5A5A,
			32'h0000_1234, 32'h0000_0010, 48'h8000_0000_0000));
		send_request(make_request(ACT_RELOAD, 6'd1, 16'd0, '0, '0, '0, 48'h1234));
		send_request(make_request(ACT_RELOAD, 6'd0, 16'd0, '0, '0, '0,
			48'hFFFF_FFFF_FFF0));
		send_request(make_request(ACT_RELOAD, 6'd0, 16'd0, '0, '0, '0, '0));
		send_request(make_request(ACT_RELOAD, 6'd2, 16'd0, '0, '0, '0,
			48'h7FFF_FFFF_FFFF));
		send_request(make_request(ACT_FREE, 6'd1, 16'd0, '0, '0, '0, '0));
		send_request(make_request(ACT_FREE, 6'd1, 16'd0, '0, '0, '0, '0));
		send_request(make_request(ACT_ALLOC, 6'd0, 16'd1, 32'h5555_AAAA, 32'd7,
			32'd3, 48'h0000_FFFF_0000));
		send_request(make_request(ACT_CANCEL, 6'd0, 16'hFFFF, '0, '0, '0, '0));
		send_request(make_request(ACT_RELOAD, 6'd0, 16'd0, '0, '0, '0, '0));
		send_request(make_request(ACT_CANCEL, 6'd0, 16'd1, '0, '0, '0, '0));
		send_request(make_request(ACT_FREE, 6'd2, 16'd0, '0, '0, '0, '0));
		idle_cycle();
		drain();

		for (int seg = 0; seg < 10; seg++) begin
			pct = idle_plan[seg % 4];
			for (int k = 0; k < 80; k++) begin
				random_request(alloc_plan[seg % 4], r);
				send_request(r);
				while ($urandom_range(99) < pct)
					idle_cycle();
			end
			if (seg == 4) begin
				idle_cycle();
				drain();
			end
		end
		idle_cycle();
		drain();
		repeat (100) @(posedge clk);
		sb.close_out();
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
src/tnp_pkg.sv
src/tnp_ram.sv
src/timer_node_pool_core.sv
bench/tnp_check_pkg.sv
bench/timer_node_pool_core_test.sv
